// ===== rtl/core/srb_pkg.sv =====
// shared types and constants for the stream reassembly buffer
package srb_pkg;

    localparam int WINDOW_BYTES_DEF = 4096;
    localparam int MAX_GAPS_DEF     = 16;
    localparam int OFFSET_BITS_DEF  = 62;

    localparam int OFFSET_W = 62;
    localparam int DIST_W   = 12;
    localparam int COUNT_W  = 13;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_PEEK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_WINDOW    = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

endpackage

// ===== rtl/core/srb_gap_table.sv =====
// gap table with a sequenced search and one-entry-per-cycle shift
module srb_gap_table #(
    parameter int MAX_GAPS    = srb_pkg::MAX_GAPS_DEF,
    parameter int OFFSET_BITS = srb_pkg::OFFSET_BITS_DEF,
    parameter int WINDOW_BYTES = srb_pkg::WINDOW_BYTES_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic [OFFSET_BITS-1:0] offset,
    input  logic [OFFSET_BITS-1:0] read_point,
    output logic                   done,
    output logic [2:0]             result,
    output logic [OFFSET_BITS:0]   head
);
    localparam int IW = $clog2(MAX_GAPS + 1);
    localparam int XW = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;

    typedef enum logic [4:0] {
        G_IDLE   = 5'b00001,
        G_SEARCH = 5'b00010,
        G_DECIDE = 5'b00100,
        G_SHIFT  = 5'b01000,
        G_DONE   = 5'b10000
    } gstate_t;

    gstate_t state_reg, state_next;
    logic [OFFSET_BITS-1:0] first_reg [MAX_GAPS];
    logic [OFFSET_BITS-1:0] last_reg [MAX_GAPS];
    logic [IW-1:0] count_reg;
    logic [IW-1:0] idx_reg;
    logic [IW-1:0] k_reg;
    logic          split_now;
    logic [2:0]    result_reg;
    logic [OFFSET_BITS-1:0] f_cur, l_cur;
    logic [OFFSET_BITS:0]   dist_w;

    assign f_cur = first_reg[idx_reg[XW-1:0]];
    assign l_cur = last_reg[idx_reg[XW-1:0]];
    assign dist_w = {1'b0, offset} - {1'b0, read_point};
    assign done = (state_reg == G_DONE);
    assign result = result_reg;
    assign head = (count_reg == '0) ? {1'b1, {OFFSET_BITS{1'b0}}} : {1'b0, first_reg[0]};
    assign split_now = !(idx_reg >= count_reg || offset < f_cur || offset < read_point)
                     && !(dist_w >= (OFFSET_BITS+1)'(WINDOW_BYTES))
                     && (f_cur != l_cur) && (offset != f_cur) && (offset != l_cur)
                     && (count_reg < IW'(MAX_GAPS));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            G_IDLE:   if (start) state_next = G_SEARCH;
            G_SEARCH: if (idx_reg >= count_reg || offset <= l_cur) state_next = G_DECIDE;
            G_DECIDE: state_next = split_now ? G_SHIFT : G_DONE;
            G_SHIFT:  if (k_reg <= idx_reg + IW'(1)) state_next = G_DONE;
            G_DONE:   state_next = G_IDLE;
            default:  state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
            count_reg <= IW'(1);
            first_reg[0] <= '0;
            last_reg[0] <= '1;
        end else begin
            state_reg <= state_next;
            unique case (state_reg)
                G_IDLE: begin
                    idx_reg <= '0;
                end
                G_SEARCH: begin
                    if (!(idx_reg >= count_reg || offset <= l_cur))
                        idx_reg <= idx_reg + IW'(1);
                end
                G_DECIDE: begin
                    k_reg <= count_reg;
                    if (idx_reg >= count_reg || offset < f_cur || offset < read_point) begin
                        result_reg <= srb_pkg::ST_DUPLICATE;
                    end else if (dist_w >= (OFFSET_BITS+1)'(WINDOW_BYTES)) begin
                        result_reg <= srb_pkg::ST_WINDOW;
                    end else if (f_cur == l_cur) begin
                        result_reg <= srb_pkg::ST_OK;
                        for (int j = 0; j < MAX_GAPS - 1; j++) begin
                            if (j >= idx_reg) begin
                                first_reg[j] <= first_reg[j+1];
                                last_reg[j] <= last_reg[j+1];
                            end
                        end
                        count_reg <= count_reg - IW'(1);
                    end else if (offset == f_cur) begin
                        result_reg <= srb_pkg::ST_OK;
                        first_reg[idx_reg[XW-1:0]] <= offset + 1'b1;
                    end else if (offset == l_cur) begin
                        result_reg <= srb_pkg::ST_OK;
                        last_reg[idx_reg[XW-1:0]] <= offset - 1'b1;
                    end else if (count_reg >= IW'(MAX_GAPS)) begin
                        result_reg <= srb_pkg::ST_FULL;
                    end else begin
                        result_reg <= srb_pkg::ST_OK;
                    end
                end
                G_SHIFT: begin
                    if (k_reg > idx_reg + IW'(1)) begin
                        first_reg[k_reg[XW-1:0]] <= first_reg[XW'(k_reg - IW'(1))];
                        last_reg[k_reg[XW-1:0]] <= last_reg[XW'(k_reg - IW'(1))];
                        k_reg <= k_reg - IW'(1);
                    end else begin
                        first_reg[XW'(idx_reg + IW'(1))] <= offset + 1'b1;
                        last_reg[XW'(idx_reg + IW'(1))] <= l_cur;
                        last_reg[idx_reg[XW-1:0]] <= offset - 1'b1;
                        count_reg <= count_reg + IW'(1);
                    end
                end
                G_DONE: ;
                default: ;
            endcase
        end
    end
endmodule

// ===== rtl/core/stream_reassembly_buffer.sv =====
// top level of the stream reassembly buffer: sequencer, ring store, result register
// Usage: s_ channel carries one beat per operation (write, read, peek); m_ channel
// returns exactly one result beat per input beat.
// A read or peek goes from S_RD through S_RDATA to the result; it goes straight
// from S_RD to the result when nothing is readable and for the unused kind; a write
// searches the gap table one entry per cycle, then decides, and when a gap splits
// moves the table entries one per cycle before the result is given.
// s_ready is high only when no beat is in work and the result register is empty;
// the next beat can be taken in the cycle after the result beat is accepted.
// The result holds on the m_ ports until m_ready; the block takes nothing new
// meanwhile. The ring store is a memory with one write port and a registered read port.
// Reset (aresetn low, synchronous) restores one gap over the whole stream,
// read point zero, and drops any pending result; store contents are not cleared
// and no clearing pass is needed since only written entries are read.
// readable_count is the first gap start minus the read point, low 13 bits.
module stream_reassembly_buffer #(
    parameter int WINDOW_BYTES = srb_pkg::WINDOW_BYTES_DEF,
    parameter int MAX_GAPS     = srb_pkg::MAX_GAPS_DEF,
    parameter int OFFSET_BITS  = srb_pkg::OFFSET_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [61:0] s_stream_offset,
    input  logic [11:0] s_peek_distance,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_byte,
    output logic        m_out_valid,
    output logic [12:0] m_readable_count,
    output logic [2:0]  m_status,
    output logic        m_end_of_request
);
    localparam int AW = $clog2(WINDOW_BYTES);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_GAP   = 5'b00010,
        S_RD    = 5'b00100,
        S_RDATA = 5'b01000,
        S_OUT   = 5'b10000
    } state_t;

    state_t state_reg;
    logic [1:0]             kind_reg;
    logic [OFFSET_BITS-1:0] off_reg;
    logic [11:0]            dist_reg;
    logic [7:0]             data_reg;
    logic                   last_reg;
    logic [OFFSET_BITS-1:0] rp_reg;
    logic [7:0]  store [WINDOW_BYTES];
    logic [7:0]  rdata_reg;
    logic [AW-1:0] raddr;
    logic          gap_start, gap_done;
    logic [2:0]    gap_result;
    logic [OFFSET_BITS:0] head, avail_w;
    logic [7:0]  ob_reg;
    logic        ov_reg;
    logic [2:0]  st_reg;
    logic [OFFSET_BITS:0] readable;
    logic        empty_rd;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_OUT);
    assign gap_start = (state_reg == S_GAP) && !gap_done && kind_reg == srb_pkg::KIND_WRITE;
    assign readable = (head >= {1'b0, rp_reg}) ? head - {1'b0, rp_reg} : '0;
    assign empty_rd = (kind_reg == srb_pkg::KIND_READ) ? (readable == '0)
                    : ({{(OFFSET_BITS-11){1'b0}}, dist_reg} >= readable);
    assign raddr = (kind_reg == srb_pkg::KIND_READ) ? rp_reg[AW-1:0]
                 : AW'(rp_reg + OFFSET_BITS'(dist_reg));
    assign avail_w = readable;

    srb_gap_table #(
        .MAX_GAPS(MAX_GAPS), .OFFSET_BITS(OFFSET_BITS), .WINDOW_BYTES(WINDOW_BYTES)
    ) u_gaps (
        .aclk(aclk), .aresetn(aresetn), .start(gap_start), .offset(off_reg),
        .read_point(rp_reg), .done(gap_done), .result(gap_result), .head(head)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == S_GAP && gap_done && gap_result == srb_pkg::ST_OK)
            store[off_reg[AW-1:0]] <= data_reg;
        rdata_reg <= store[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            rp_reg <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        kind_reg <= s_kind;
                        off_reg <= s_stream_offset[OFFSET_BITS-1:0];
                        dist_reg <= s_peek_distance;
                        data_reg <= s_data_byte;
                        last_reg <= s_last_byte;
                        ob_reg <= '0;
                        ov_reg <= 1'b0;
                        st_reg <= srb_pkg::ST_OK;
                        state_reg <= (s_kind == srb_pkg::KIND_WRITE) ? S_GAP : S_RD;
                    end
                end
                S_GAP: begin
                    if (gap_done) begin
                        st_reg <= gap_result;
                        state_reg <= S_OUT;
                    end
                end
                S_RD: begin
                    if (kind_reg == srb_pkg::KIND_NONE) begin
                        state_reg <= S_OUT;
                    end else if (empty_rd) begin
                        st_reg <= srb_pkg::ST_EMPTY;
                        state_reg <= S_OUT;
                    end else begin
                        state_reg <= S_RDATA;
                    end
                end
                S_RDATA: begin
                    ob_reg <= rdata_reg;
                    ov_reg <= 1'b1;
                    if (kind_reg == srb_pkg::KIND_READ)
                        rp_reg <= rp_reg + 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign m_out_byte = ob_reg;
    assign m_out_valid = ov_reg;
    assign m_readable_count = avail_w[12:0];
    assign m_status = st_reg;
    assign m_end_of_request = last_reg;
endmodule
